@@ rtl/core/dosr_pkg.sv @@
// shared constants, sine table entry function and helper functions for the oscillator pair
package dosr_pkg;

    localparam int SineDepth = 1024;
    localparam int SineIdxW  = $clog2(SineDepth);

    localparam logic [2:0] CfgPitchLow  = 3'd0;
    localparam logic [2:0] CfgPitchHigh = 3'd1;
    localparam logic [2:0] CfgGainLow   = 3'd2;
    localparam logic [2:0] CfgGainHigh  = 3'd3;
    localparam logic [2:0] CfgStep      = 3'd4;

    localparam logic [31:0] PhaseTwoReset = 32'd205069583;

    localparam longint Q30C1 = 64'sd1686629713;
    localparam longint Q30C3 = -64'sd693598668;
    localparam longint Q30C5 = 64'sd85569306;
    localparam longint Q30C7 = -64'sd5026996;
    localparam longint Q30C9 = 64'sd172272;

    typedef logic [15:0] sine_val_t;

    // truncating signed multiply and shift, only used at elaboration
    function automatic longint mul_shift(longint a, longint b, int sh);
        logic   neg;
        longint ua;
        longint ub;
        longint p;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        p   = (ua * ub) >>> sh;
        return neg ? -p : p;
    endfunction

    function automatic sine_val_t sine_entry(int k);
        longint x;
        longint x2;
        longint acc;
        longint y;
        longint s;
        x   = (longint'(k) <<< 30) / SineDepth;
        x2  = mul_shift(x, x, 30);
        acc = Q30C9;
        acc = Q30C7 + mul_shift(acc, x2, 30);
        acc = Q30C5 + mul_shift(acc, x2, 30);
        acc = Q30C3 + mul_shift(acc, x2, 30);
        acc = Q30C1 + mul_shift(acc, x2, 30);
        y   = mul_shift(acc, x, 30);
        s   = (y > 0) ? ((y + 64'sd16384) >>> 15) : 64'sd0;
        if (s > 32767) begin
            s = 32767;
        end
        return sine_val_t'(s);
    endfunction

endpackage

@@ rtl/core/dosr_divider.sv @@
// radix-2 restoring divider, one quotient bit per cycle, unsigned operands
module dosr_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [41:0] dividend,
    input  logic [41:0] divisor,
    output logic        done,
    output logic [41:0] quotient
);

    logic [41:0] quo_reg, quo_next;
    logic [42:0] rem_reg, rem_next;
    logic [41:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [42:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[41:0], quo_reg[41]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[40:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[40:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd41) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/dual_oscillator_ratio_synth.sv @@
// top level: two table oscillators, sensor mapping and voice ratio
// One transaction in gives one transaction out. Each sample passes through three
// 42-step bit-serial divisions on one shared divider (pitch map, gain map, voice
// ratio), plus the operand setup, table reads, phase update and output load. When
// the second voice is zero the ratio division is skipped. A new sample is taken
// only after the result is loaded into the output register and the block is back
// in idle; a stalled receiver holds back that load. Configuration writes are taken
// at any time and must only be issued while the block is idle. After reset the
// phases are 0 and 0.3 radian.
module dual_oscillator_ratio_synth (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // pitch_reading[15:0], gain_reading[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // ratio_sample, first_voice, second_voice
    output logic        m_tuser,    // divide_fault
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam logic [3:0] StIdle   = 4'd0;
    localparam logic [3:0] StPDiv   = 4'd1;
    localparam logic [3:0] StPWait  = 4'd2;
    localparam logic [3:0] StGDiv   = 4'd3;
    localparam logic [3:0] StGWait  = 4'd4;
    localparam logic [3:0] StVoice  = 4'd5;
    localparam logic [3:0] StVoice2 = 4'd6;
    localparam logic [3:0] StRDiv   = 4'd7;
    localparam logic [3:0] StRWait  = 4'd8;
    localparam logic [3:0] StStep   = 4'd9;
    localparam logic [3:0] StOut    = 4'd10;

    localparam logic [25:0] F50   = 26'd3276800;
    localparam logic [25:0] F100  = 26'd6553600;
    localparam logic [25:0] F1000 = 26'd65536000;
    localparam logic [41:0] F900  = 42'd58982400;

    localparam int SineDepthP1 = dosr_pkg::SineDepth + 1;
    localparam int SineIdxW    = dosr_pkg::SineIdxW;
    localparam logic [SineIdxW:0] SineTop = (SineIdxW+1)'(dosr_pkg::SineDepth);

    logic [15:0] plo_reg, phi_reg, glo_reg, ghi_reg;
    logic [23:0] step_reg;
    logic [31:0] ph1_reg, ph2_reg;
    logic [3:0]  st_reg, st_next;
    logic [15:0] pr_reg, gr_reg;
    logic [25:0] f1_reg, f2_reg;
    logic [15:0] a1_reg;
    logic [12:0] a2_reg;
    logic        neg_reg;
    logic signed [15:0] v1_reg, v2_reg;
    dosr_pkg::sine_val_t t1_reg, t2_reg;
    logic        mv_reg;
    logic [55:0] md_reg;
    logic        mu_reg;

    dosr_pkg::sine_val_t sine_rom [SineDepthP1];

    generate
        for (genvar k = 0; k < SineDepthP1; k++) begin : g_rom
            assign sine_rom[k] = dosr_pkg::sine_entry(k);
        end
    endgenerate

    // division operands
    logic        d_start;
    logic [41:0] d_num, d_den, d_q;
    logic        d_done;

    dosr_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(d_start),
        .dividend(d_num), .divisor(d_den), .done(d_done), .quotient(d_q)
    );

    // signed map operands
    logic signed [16:0] p_dif, p_den, g_dif, g_den;
    assign p_dif = $signed({1'b0, pr_reg}) - $signed({1'b0, plo_reg});
    assign p_den = $signed({1'b0, phi_reg}) - $signed({1'b0, plo_reg});
    assign g_dif = $signed({1'b0, gr_reg}) - $signed({1'b0, glo_reg});
    assign g_den = $signed({1'b0, ghi_reg}) - $signed({1'b0, glo_reg});

    function automatic logic [16:0] mag17(input logic signed [16:0] v);
        return v[16] ? 17'(-v) : 17'(v);
    endfunction

    // table addresses: odd quadrants read the table backwards
    logic [SineIdxW:0] adr1, adr2;
    assign adr1 = ph1_reg[30] ? SineTop - {1'b0, ph1_reg[29 -: SineIdxW]} :
                                {1'b0, ph1_reg[29 -: SineIdxW]};
    assign adr2 = ph2_reg[30] ? SineTop - {1'b0, ph2_reg[29 -: SineIdxW]} :
                                {1'b0, ph2_reg[29 -: SineIdxW]};

    logic [32:0] prod1;
    logic [28:0] prod2;
    assign prod1 = 33'(a1_reg) * 33'(t1_reg);
    assign prod2 = 29'(a2_reg) * 29'(t2_reg);

    logic signed [16:0] v1w, v2w;
    assign v1w = ph1_reg[31] ? -$signed({1'b0, prod1[30:15]}) : $signed({1'b0, prod1[30:15]});
    assign v2w = ph2_reg[31] ? -$signed({3'b0, prod2[28:15]}) :
                               $signed({3'b0, prod2[28:15]});

    logic [49:0] step1, step2;
    assign step1 = 50'(f1_reg) * 50'(step_reg);
    assign step2 = 50'(f2_reg) * 50'(step_reg);

    // f2 = f1 + f1/100, the division by reciprocal multiplication
    logic [52:0] f2q_prod;
    assign f2q_prod = 53'(f1_reg) * 53'd85899346;

    // a2 = (a1 + 5) / 10 by reciprocal multiplication
    logic [32:0] a2_prod;
    assign a2_prod = 33'({1'b0, a1_reg} + 17'd5) * 33'd52429;

    logic [25:0] f1_new;
    always_comb begin
        if (p_den == 17'sd0) begin
            f1_new = p_dif[16] ? F50 : ((p_dif == 17'sd0) ? F100 : F1000);
        end else if (neg_reg) begin
            f1_new = (d_q > {16'd0, F50}) ? F50 : F100 - d_q[25:0];
        end else begin
            f1_new = (d_q > F900) ? F1000 : F100 + d_q[25:0];
        end
    end

    logic [23:0] ratio_w;
    always_comb begin
        if (!neg_reg) begin
            ratio_w = (d_q > 42'd8388607) ? 24'h7FFFFF : d_q[23:0];
        end else begin
            ratio_w = (d_q > 42'd8388608) ? 24'h800000 : 24'd0 - d_q[23:0];
        end
    end

    logic s_fire;
    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = (st_reg == StIdle);
    assign cfg_ready = 1'b1;

    always_comb begin
        st_next = st_reg;
        d_start = 1'b0;
        d_num   = '0;
        d_den   = '0;
        unique case (st_reg)
            StIdle:   if (s_fire) st_next = StPDiv;
            StPDiv: begin
                d_start = 1'b1;
                d_num   = 42'(mag17(p_dif)) * F900;
                d_den   = 42'(mag17(p_den));
                st_next = StPWait;
            end
            StPWait:  if (d_done) st_next = StGDiv;
            StGDiv: begin
                d_start = 1'b1;
                d_num   = 42'({mag17(g_dif), 15'd0});
                d_den   = 42'(mag17(g_den));
                st_next = StGWait;
            end
            StGWait:  if (d_done) st_next = StVoice;
            StVoice:  st_next = StVoice2;
            StVoice2: st_next = (v2w == 17'sd0) ? StStep : StRDiv;
            StRDiv: begin
                d_start = 1'b1;
                d_num   = {8'd0, mag17({v1_reg[15], v1_reg}), 17'd0};
                d_den   = {25'd0, mag17({v2_reg[15], v2_reg})};
                st_next = StRWait;
            end
            StRWait:  if (d_done) st_next = StStep;
            StStep:   st_next = StOut;
            StOut:    if (!mv_reg || m_tready) st_next = StIdle;
            default:  st_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pr_reg <= s_tdata[15:0];
            gr_reg <= s_tdata[31:16];
        end
        if (st_reg == StPDiv) neg_reg <= p_dif[16] ^ p_den[16];
        if (st_reg == StGDiv) neg_reg <= g_dif[16] ^ g_den[16];
        if (st_reg == StRDiv) neg_reg <= v1_reg[15] ^ v2_reg[15];
        if (st_reg == StPWait && d_done) f1_reg <= f1_new;
        if (st_reg == StGDiv) f2_reg <= 26'(f2q_prod[52:33]);
        if (st_reg == StGWait && d_done) begin
            if (g_den == 17'sd0) begin
                a1_reg <= (!g_dif[16] && g_dif != 17'sd0) ? 16'd32768 : 16'd0;
            end else if (neg_reg && d_q != 42'd0) begin
                a1_reg <= 16'd0;
            end else if (d_q > 42'd32768) begin
                a1_reg <= 16'd32768;
            end else begin
                a1_reg <= d_q[15:0];
            end
        end
        if (st_reg == StVoice) begin
            a2_reg <= a2_prod[31:19];
            f2_reg <= f2_reg + f1_reg;
            t1_reg <= sine_rom[adr1];
            t2_reg <= sine_rom[adr2];
        end
        if (st_reg == StVoice2) begin
            v1_reg <= v1w[15:0];
            v2_reg <= v2w[15:0];
        end
        if (st_reg == StOut && (!mv_reg || m_tready)) begin
            if (v2_reg == 16'sd0) begin
                md_reg <= {v2_reg, v1_reg, 24'd0};
                mu_reg <= 1'b1;
            end else begin
                md_reg <= {v2_reg, v1_reg, ratio_w};
                mu_reg <= 1'b0;
            end
        end
        if (!aresetn) begin
            st_reg   <= StIdle;
            mv_reg   <= 1'b0;
            plo_reg  <= 16'd0;
            phi_reg  <= 16'd28835;
            glo_reg  <= 16'd9861;
            ghi_reg  <= 16'd13959;
            step_reg <= 24'd97391;
            ph1_reg  <= '0;
            ph2_reg  <= dosr_pkg::PhaseTwoReset;
        end else begin
            st_reg <= st_next;
            // the output state only loads once the register is free or being read out
            mv_reg <= (st_reg == StOut) ? 1'b1 : (mv_reg && !m_tready);
            if (st_reg == StStep) begin
                ph1_reg <= ph1_reg + step1[47:16];
                ph2_reg <= ph2_reg + step2[47:16];
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    dosr_pkg::CfgPitchLow:  plo_reg  <= cfg_data[15:0];
                    dosr_pkg::CfgPitchHigh: phi_reg  <= cfg_data[15:0];
                    dosr_pkg::CfgGainLow:   glo_reg  <= cfg_data[15:0];
                    dosr_pkg::CfgGainHigh:  ghi_reg  <= cfg_data[15:0];
                    dosr_pkg::CfgStep:      step_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

endmodule

@@ rtl/core/dosr_checker.sv @@
// port-level checks for the oscillator pair
module dosr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);

    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[23:0] == 24'd0 && m_tdata[55:40] == 16'd0)
        else $error("fault without zero ratio");

    a_nofault_div: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[55:40] != 16'd0)
        else $error("zero divisor without fault");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    a_one_at_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second sample taken during work");

endmodule

bind dual_oscillator_ratio_synth dosr_checker u_dosr_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
